// File: sv/sse_pkg.sv
// sse_pkg: shared types, character constants and classification functions
// for the string escape encoder. Used by every module under sv/.
package sse_pkg;

  localparam int QUEUE_DEPTH = 2;                       // power of two
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_NONE   = 8'h00;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_word_t;

  // One classified input byte: optional extra backslash, optional escape
  // backslash, then the final byte.
  typedef struct packed {
    logic       pre_bs;
    logic       esc;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic [7:0] escape_letter(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_BEL:    r = CH_A;
      CH_BS:     r = CH_B;
      CH_FF:     r = CH_F;
      CH_LF:     r = CH_N;
      CH_CR:     r = CH_R;
      CH_TAB:    r = CH_T;
      CH_VT:     r = CH_V;
      CH_SQUOTE: r = CH_SQUOTE;
      CH_DQUOTE: r = CH_DQUOTE;
      default:   r = CH_NONE;
    endcase
    return r;
  endfunction

  function automatic logic reads_as_escape(input logic [7:0] c);
    return c inside {CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V, CH_SQUOTE, CH_DQUOTE};
  endfunction

endpackage

// File: sv/string_escape_encoder.sv
// string_escape_encoder: top level, front classifier -> command queue ->
// output serializer. Depends on sse_pkg, sse_front, sse_queue, sse_back.
//
//   channel  | dir | handshake             | word
//   text     | in  | text_valid/text_ready | in_char, end_of_text
//   esc      | out | esc_valid/esc_ready   | out_char, last_of_run
//
// Each text word produces 1 to 3 esc words, one per cycle from the output
// register while esc_ready allows; the output port sets the rate.
// A text word is written into the queue, then its first esc word is loaded into the output register.
// rst (synchronous) clears the pending mark, the queue and the output stage.
// Stalls on esc back up into the two-entry queue, then drop text_ready.
module string_escape_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_ready,
  input  sse_pkg::in_word_t  text,
  output logic               esc_valid,
  input  logic               esc_ready,
  output sse_pkg::out_word_t esc
);

  logic                      push;
  logic                      q_ready;
  logic                      pop;
  logic                      head_valid;
  logic                      pending;
  sse_pkg::cmd_t             wr_cmd;
  sse_pkg::cmd_t             head;
  logic [sse_pkg::CNT_W-1:0] count;

  sse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text),
    .q_ready    (q_ready),
    .push       (push),
    .cmd        (wr_cmd),
    .pending    (pending)
  );

  sse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_cmd     (wr_cmd),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (count)
  );

  sse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .esc_valid  (esc_valid),
    .esc_ready  (esc_ready),
    .esc        (esc)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sse_pkg::CNT_W'(sse_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_lead_is_bslash: assert property (@(posedge clk) disable iff (rst)
    esc_valid && !esc.last_of_run |-> esc.out_char == sse_pkg::CH_BSLASH)
    else $error("non-final byte of a run is not a backslash");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && text.end_of_text |=> !pending)
    else $error("pending mark survived end of text");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");
`endif

endmodule

// File: sv/sse_front.sv
// sse_front: accepts text words, tracks the pending-backslash mark and
// classifies each byte into a command for the queue. Depends on sse_pkg.
module sse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  output logic              text_ready,
  input  sse_pkg::in_word_t text,
  input  logic              q_ready,
  output logic              push,
  output sse_pkg::cmd_t     cmd,
  output logic              pending
);

  logic       pending_next;
  logic [7:0] letter;
  logic       pair;

  assign text_ready = q_ready;
  assign push       = text_valid && q_ready;

  always_comb begin
    letter = sse_pkg::escape_letter(text.in_char);
    pair   = pending && (text.in_char == sse_pkg::CH_BSLASH);
    cmd.pre_bs = pending && sse_pkg::reads_as_escape(text.in_char);
    cmd.esc    = (letter != sse_pkg::CH_NONE) && !pair;
    if (pair) begin
      cmd.ch = sse_pkg::CH_BSLASH;
    end else if (letter != sse_pkg::CH_NONE) begin
      cmd.ch = letter;
    end else begin
      cmd.ch = text.in_char;
    end
    // a backslash pair ends the mark; end of text always clears it
    pending_next = !pair && (text.in_char == sse_pkg::CH_BSLASH) && !text.end_of_text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (push) begin
      pending <= pending_next;
    end
  end

endmodule

// File: sv/sse_queue.sv
// sse_queue: short FIFO of classified commands between front and back.
// Depends on sse_pkg for the command type and depth constants.
module sse_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  sse_pkg::cmd_t            wr_cmd,
  output logic                     q_ready,
  input  logic                     pop,
  output logic                     head_valid,
  output sse_pkg::cmd_t            head,
  output logic [sse_pkg::CNT_W-1:0] count
);

  sse_pkg::cmd_t             mem [sse_pkg::QUEUE_DEPTH];
  logic [sse_pkg::PTR_W-1:0] wr_ptr;
  logic [sse_pkg::PTR_W-1:0] rd_ptr;

  assign q_ready    = count != sse_pkg::CNT_W'(sse_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/sse_back.sv
// sse_back: expands the head command into one to three output words, one
// per cycle while esc is not stalled, into a registered output stage. Depends on sse_pkg.
module sse_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  sse_pkg::cmd_t      head,
  output logic               pop,
  output logic               esc_valid,
  input  logic               esc_ready,
  output sse_pkg::out_word_t esc
);

  logic [1:0]         phase;
  logic [1:0]         last_phase;
  logic               load;
  logic               is_last;
  sse_pkg::out_word_t word_next;

  always_comb begin
    last_phase = {1'b0, head.pre_bs} + {1'b0, head.esc};
    is_last    = phase == last_phase;
    load       = head_valid && (!esc_valid || esc_ready);
    pop        = load && is_last;
    // every byte before the last one is a backslash
    word_next.out_char    = is_last ? head.ch : sse_pkg::CH_BSLASH;
    word_next.last_of_run = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      esc_valid <= 1'b0;
    end else begin
      if (load) begin
        phase     <= is_last ? 2'd0 : phase + 2'd1;
        esc_valid <= 1'b1;
      end else if (esc_ready) begin
        esc_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      esc <= word_next;
    end
  end

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for string_escape_encoder, a byte stream escaper.
// Holds its own escape predictor and checks each esc word in order.
// Depends on sse_pkg and string_escape_encoder under sv/.
module tb;

  localparam int RANDOM_WORDS = 175;
  localparam int LONG_HOLD    = 90;
  localparam int TAIL_CYCLES  = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 60;

  // escape letter for the control bytes BEL..CR, in byte order
  localparam logic [7:0] CTRL_LETTER [7] = '{sse_pkg::CH_A, sse_pkg::CH_B, sse_pkg::CH_T,
                                             sse_pkg::CH_N, sse_pkg::CH_V, sse_pkg::CH_F,
                                             sse_pkg::CH_R};

  typedef struct {
    sse_pkg::in_word_t w;
    int                nexp;   // 0: take the predictor's answer
    logic [2:0][7:0]   ech;
  } text_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               text_valid;
  logic               text_ready;
  sse_pkg::in_word_t  text;
  logic               esc_valid;
  logic               esc_ready;
  sse_pkg::out_word_t esc;

  sse_pkg::out_word_t escaped_due [$];
  text_row_t          stim_rows [$];
  sse_pkg::out_word_t want;
  logic               after_lone_bslash;
  logic               hold_off_req = 1'b0;
  logic               hold_done = 1'b0;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;

  string_escape_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text      (text),
    .esc_valid (esc_valid),
    .esc_ready (esc_ready),
    .esc       (esc)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("[%0d] MISMATCH: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Escaped form of one text byte; advances the lone-backslash mark.
  function automatic int escape_byte(input sse_pkg::in_word_t w,
                                     output logic [2:0][7:0] seq);
    logic [7:0] c;
    logic [7:0] code;
    logic       quotable;
    int         n;
    c = w.in_char;
    code = sse_pkg::CH_NONE;
    quotable = (c == sse_pkg::CH_SQUOTE) || (c == sse_pkg::CH_DQUOTE);
    n = 0;
    seq = '0;
    if (c >= sse_pkg::CH_BEL && c <= sse_pkg::CH_CR)
      code = CTRL_LETTER[c - sse_pkg::CH_BEL];
    else if (quotable)
      code = c;
    for (int i = 0; i < 7; i++)
      if (c == CTRL_LETTER[i]) quotable = 1'b1;
    if (after_lone_bslash && c == sse_pkg::CH_BSLASH) begin
      seq[0] = sse_pkg::CH_BSLASH;
      n = 1;
      after_lone_bslash = 1'b0;
    end else begin
      if (after_lone_bslash && quotable) begin
        seq[n] = sse_pkg::CH_BSLASH;
        n++;
      end
      if (code != sse_pkg::CH_NONE) begin
        seq[n] = sse_pkg::CH_BSLASH;
        seq[n + 1] = code;
        n += 2;
      end else begin
        seq[n] = c;
        n++;
      end
      after_lone_bslash = (c == sse_pkg::CH_BSLASH);
    end
    if (w.end_of_text) after_lone_bslash = 1'b0;
    return n;
  endfunction

  function automatic void add_row(input logic [7:0] ch, input logic eot, input int nexp,
                                  input logic [7:0] e0 = sse_pkg::CH_NONE,
                                  input logic [7:0] e1 = sse_pkg::CH_NONE,
                                  input logic [7:0] e2 = sse_pkg::CH_NONE);
    text_row_t r;
    r.w = '{in_char: ch, end_of_text: eot};
    r.nexp = nexp;
    r.ech[0] = e0;
    r.ech[1] = e1;
    r.ech[2] = e2;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  // Biased toward backslashes, control bytes, quotes and escape letters.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = sse_pkg::CH_BSLASH;
      3, 4:    c = 8'($urandom_range(sse_pkg::CH_BEL, sse_pkg::CH_CR));
      5:       c = $urandom_range(0, 1) ? sse_pkg::CH_SQUOTE : sse_pkg::CH_DQUOTE;
      6:       c = CTRL_LETTER[$urandom_range(0, 6)];
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // Starts and ends at a falling edge; predicts at the accepting edge.
  task automatic send_row(input text_row_t r);
    logic [2:0][7:0] seq;
    int              n;
    text_valid <= 1'b1;
    text <= r.w;
    do @(posedge clk); while (!text_ready);
    n = escape_byte(r.w, seq);
    if (r.nexp != 0) begin
      n = r.nexp;
      seq = r.ech;
    end
    for (int k = 0; k < n; k++)
      escaped_due.insert(escaped_due.size(), sse_pkg::out_word_t'{seq[k], k == n - 1});
    @(negedge clk);
  endtask

  task automatic drain_pause();
    text_valid <= 1'b0;
    @(negedge clk);
    while (escaped_due.size() != 0) @(negedge clk);
  endtask

  // Receiver: stretches of always-ready, coin-flip and periodic ready,
  // plus one long hold-off when the sender asks for it.
  initial begin
    int mode;
    int span;
    int period;
    esc_ready = 1'b0;
    forever begin
      if (hold_off_req && !hold_done) begin
        esc_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(4, 40);
        period = $urandom_range(2, 5);
        for (int k = 0; k < span; k++) begin
          case (mode)
            0:       esc_ready <= 1'b1;
            1:       esc_ready <= 1'($urandom_range(0, 1));
            default: esc_ready <= (k % period) == 0;
          endcase
          @(negedge clk);
          if (hold_off_req && !hold_done) break;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && esc_valid && esc_ready) begin
      if (escaped_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word out_char=%h last_of_run=%b",
                                  esc.out_char, esc.last_of_run));
      end else begin
        want = escaped_due.pop_front();
        if (esc.out_char !== want.out_char)
          report_mismatch($sformatf("out_char got %h want %h", esc.out_char, want.out_char));
        if (esc.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run got %b want %b (out_char %h)",
                                    esc.last_of_run, want.last_of_run, want.out_char));
      end
    end
  end

  initial begin
    int n_directed;
    int burst_left;
    int gap;
    rst = 1'b1;
    text_valid = 1'b0;
    text = '0;
    after_lone_bslash = 1'b0;

    // extremes, every escape, then the lone-backslash cases
    add_row(8'h00, 1'b0, 1, 8'h00);
    add_row(8'hFF, 1'b0, 1, 8'hFF);
    add_row(sse_pkg::CH_BEL, 1'b0, 2, sse_pkg::CH_BSLASH, sse_pkg::CH_A);
    add_row(sse_pkg::CH_BS, 1'b0, 2, sse_pkg::CH_BSLASH, sse_pkg::CH_B);
    add_row(sse_pkg::CH_FF, 1'b0, 2, sse_pkg::CH_BSLASH, sse_pkg::CH_F);
    add_row(sse_pkg::CH_LF, 1'b0, 2, sse_pkg::CH_BSLASH, sse_pkg::CH_N);
    add_row(sse_pkg::CH_CR, 1'b0, 2, sse_pkg::CH_BSLASH, sse_pkg::CH_R);
    add_row(sse_pkg::CH_TAB, 1'b0, 2, sse_pkg::CH_BSLASH, sse_pkg::CH_T);
    add_row(sse_pkg::CH_VT, 1'b0, 2, sse_pkg::CH_BSLASH, sse_pkg::CH_V);
    add_row(sse_pkg::CH_SQUOTE, 1'b0, 2, sse_pkg::CH_BSLASH, sse_pkg::CH_SQUOTE);
    add_row(sse_pkg::CH_DQUOTE, 1'b0, 2, sse_pkg::CH_BSLASH, sse_pkg::CH_DQUOTE);
    add_row(sse_pkg::CH_A, 1'b0, 0);
    add_row(sse_pkg::CH_BSLASH, 1'b0, 0);
    add_row(sse_pkg::CH_BSLASH, 1'b0, 0);          // backslash pair
    add_row(sse_pkg::CH_BSLASH, 1'b0, 0);
    add_row(sse_pkg::CH_N, 1'b0, 0);               // letter after lone backslash
    add_row(sse_pkg::CH_BSLASH, 1'b0, 0);
    add_row(sse_pkg::CH_DQUOTE, 1'b0, 3,
            sse_pkg::CH_BSLASH, sse_pkg::CH_BSLASH, sse_pkg::CH_DQUOTE);
    add_row(sse_pkg::CH_BSLASH, 1'b0, 0);
    add_row(sse_pkg::CH_LF, 1'b0, 0);              // control byte after lone backslash
    add_row(sse_pkg::CH_BSLASH, 1'b1, 1, sse_pkg::CH_BSLASH);
    add_row(sse_pkg::CH_T, 1'b0, 1, sse_pkg::CH_T); // end of text cleared the mark
    add_row(sse_pkg::CH_BSLASH, 1'b0, 0);
    add_row(8'h71, 1'b0, 0);
    add_row(8'h80, 1'b1, 1, 8'h80);
    n_directed = stim_rows.size();

    for (int i = 0; i < RANDOM_WORDS; i++)
      add_row(pick_char(), $urandom_range(0, 9) == 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    burst_left = 0;
    foreach (stim_rows[i]) begin
      if (i == n_directed || i == n_directed + 130) begin
        drain_pause();
        burst_left = 0;
      end
      if (i == n_directed + 60) hold_off_req = 1'b1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          text_valid <= 1'b0;
          text <= sse_pkg::in_word_t'(9'($urandom));
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      send_row(stim_rows[i]);
    end

    text_valid <= 1'b0;
    while (escaped_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
